// ===== design/bhts_pkg.sv =====
// Shared types and codes for the sorted-bucket hash table.
// Used by bhts_ctrl, bhts_dpath and the top level; depends on nothing.
`default_nettype none

package bhts_pkg;

  // Field widths fixed by the interface
  localparam int KEY_W     = 31;
  localparam int ENTRY_W   = KEY_W + 2;
  localparam int BIT_CNT_W = $clog2(KEY_W);

  // Actions
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_RSVD   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_PLACED = 2'd0;
  localparam logic [1:0] ST_FOUND  = 2'd1;
  localparam logic [1:0] ST_MISS   = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // Slot marks
  localparam logic [1:0] MK_EMPTY = 2'd0;
  localparam logic [1:0] MK_LIVE  = 2'd1;
  localparam logic [1:0] MK_TOMB  = 2'd2;

  // Configuration register indexes and reset values
  localparam logic       CFG_FLOORS = 1'b0;
  localparam logic       CFG_SLOTS  = 1'b1;
  localparam logic [4:0] FLOORS_RST = 5'd16;
  localparam logic [3:0] SLOTS_RST  = 4'd8;

  // Commands from controller to datapath
  typedef struct packed {
    logic       clr;
    logic       load;
    logic       mod_step;
    logic       probe_adv;
    logic       scan_begin;
    logic       scan_rd;
    logic       scan_chk;
    logic       shift_rd;
    logic       shift_wr;
    logic       place;
    logic       srch_rd;
    logic       srch_chk;
    logic       fin;
    logic [1:0] fin_status;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic in_bad;
    logic in_add;
    logic mod_last;
    logic probe_full;
    logic probe_out;
    logic scan_empty;
    logic scan_last;
    logic pos_set;
    logic shift_last;
    logic range_empty;
    logic last_floor;
    logic srch_hit;
    logic srch_tomb;
    logic q_remove;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/bhts_ram.sv =====
// Generic simple dual-port RAM with registered read.
// Standalone; no package needed.
`default_nettype none

module bhts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/bhts_ctrl.sv =====
// Controller state machine for the sorted-bucket hash table.
// Depends on bhts_pkg for command and status structs and codes.
`default_nettype none

module bhts_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire bhts_pkg::dp_stat_t stat,
  output bhts_pkg::dp_cmd_t       cmd,
  output logic                    busy
);
  import bhts_pkg::*;

  typedef enum logic [11:0] {
    S_CLEAR     = 12'b0000_0000_0001,
    S_IDLE      = 12'b0000_0000_0010,
    S_MOD       = 12'b0000_0000_0100,
    S_PROBE_RD  = 12'b0000_0000_1000,
    S_PROBE_CHK = 12'b0000_0001_0000,
    S_SCAN_RD   = 12'b0000_0010_0000,
    S_SCAN_CHK  = 12'b0000_0100_0000,
    S_SHIFT_RD  = 12'b0000_1000_0000,
    S_SHIFT_WR  = 12'b0001_0000_0000,
    S_PLACE     = 12'b0010_0000_0000,
    S_SRCH_RD   = 12'b0100_0000_0000,
    S_SRCH_CHK  = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Sequence the operation
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.in_bad) begin
            cmd.fin        = 1'b1;
            cmd.fin_status = ST_MISS;
          end else if (stat.in_add) begin
            state_next = S_MOD;
          end else begin
            state_next = S_SRCH_RD;
          end
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) state_next = S_PROBE_RD;
      end
      S_PROBE_RD: begin
        state_next = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (!stat.probe_full) begin
          cmd.scan_begin = 1'b1;
          state_next     = S_SCAN_RD;
        end else if (stat.probe_out) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_FULL;
          state_next     = S_IDLE;
        end else begin
          cmd.probe_adv = 1'b1;
          state_next    = S_PROBE_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        if (stat.scan_empty) begin
          state_next = stat.pos_set ? S_SHIFT_RD : S_PLACE;
        end else if (stat.scan_last) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_FULL;
          state_next     = S_IDLE;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd.shift_rd = 1'b1;
        state_next   = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = stat.shift_last ? S_PLACE : S_SHIFT_RD;
      end
      S_PLACE: begin
        cmd.place      = 1'b1;
        cmd.fin        = 1'b1;
        cmd.fin_status = ST_PLACED;
        state_next     = S_IDLE;
      end
      S_SRCH_RD: begin
        cmd.srch_rd = 1'b1;
        if (!stat.range_empty) begin
          state_next = S_SRCH_CHK;
        end else if (stat.last_floor) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_MISS;
          state_next     = S_IDLE;
        end
      end
      S_SRCH_CHK: begin
        cmd.srch_chk = 1'b1;
        if (stat.srch_hit) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = (stat.q_remove || !stat.srch_tomb) ? ST_FOUND : ST_MISS;
          state_next     = S_IDLE;
        end else begin
          state_next = S_SRCH_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/bhts_dpath.sv =====
// Datapath: slot and fill memories, modulo unit, probe, scan, shift and search registers.
// Depends on bhts_pkg and bhts_ram.
`default_nettype none

module bhts_dpath #(
  parameter int FLOORS = 16,
  parameter int SLOTS  = 8
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire bhts_pkg::dp_cmd_t                            cmd,
  output bhts_pkg::dp_stat_t                                stat,
  input  wire logic [1:0]                                   action,
  input  wire logic [bhts_pkg::KEY_W-1:0]                   key,
  input  wire logic [4:0]                                   floors_cfg,
  input  wire logic [3:0]                                   slots_cfg,
  output logic                                              done,
  output logic [1:0]                                        status,
  output logic [((FLOORS > 1) ? $clog2(FLOORS) : 1)-1:0]    floor,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]      slot
);
  import bhts_pkg::*;

  localparam int FW  = (FLOORS > 1) ? $clog2(FLOORS) : 1;
  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CFW = $clog2(FLOORS + 1);
  localparam int CSW = $clog2(SLOTS + 1);
  localparam int AW  = FW + SW;

  logic [CFW-1:0]       nf;
  logic [CSW-1:0]       ns;
  logic [KEY_W-1:0]     key_q;
  logic [1:0]           act_q;
  logic [CFW-1:0]       rem_q;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [FW-1:0]        bkt;
  logic [CFW-1:0]       tries;
  logic [CSW-1:0]       fill_q;
  logic [SW-1:0]        idx;
  logic [SW-1:0]        pos_q;
  logic                 pos_ok;
  logic [CSW-1:0]       lo;
  logic [CSW-1:0]       hi_ex;
  logic [SW-1:0]        mid_q;
  logic [FW-1:0]        flr;
  logic [AW-1:0]        clr_addr;

  logic [CFW:0]         rem_sh;
  logic [CFW-1:0]       rem_n;
  logic [SW-1:0]        idx_dn;
  logic [CSW:0]         mid_sum;
  logic [SW-1:0]        mid_w;
  logic [ENTRY_W-1:0]   rd_entry;
  logic [KEY_W-1:0]     rd_key;
  logic [1:0]           rd_mark;
  logic [CSW-1:0]       fill_rd;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic                 fill_we;
  logic [FW-1:0]        fill_waddr;
  logic [CSW-1:0]       fill_wdata;

  // Clamp the configured sizes
  always_comb begin
    if (floors_cfg == '0) begin
      nf = CFW'(1);
    end else if (32'(floors_cfg) > FLOORS) begin
      nf = CFW'(FLOORS);
    end else begin
      nf = CFW'(floors_cfg);
    end
    if (slots_cfg == '0) begin
      ns = CSW'(1);
    end else if (32'(slots_cfg) > SLOTS) begin
      ns = CSW'(SLOTS);
    end else begin
      ns = CSW'(slots_cfg);
    end
  end

  // Restoring remainder step, one key bit per cycle
  assign rem_sh = {rem_q, key_q[bit_cnt]};
  assign rem_n  = (rem_sh >= {1'b0, nf}) ? CFW'(rem_sh - {1'b0, nf}) : CFW'(rem_sh);

  assign idx_dn  = idx - SW'(1);
  assign mid_sum = (CSW+1)'(lo) + (CSW+1)'(hi_ex) - (CSW+1)'(1);
  assign mid_w   = SW'(mid_sum >> 1);

  assign rd_key  = rd_entry[ENTRY_W-1:2];
  assign rd_mark = rd_entry[1:0];

  // Status to the controller
  always_comb begin
    stat.clr_last    = &clr_addr;
    stat.in_bad      = (key == '0) || (action == ACT_RSVD);
    stat.in_add      = (action == ACT_ADD);
    stat.mod_last    = (bit_cnt == '0);
    stat.probe_full  = (fill_rd >= ns);
    stat.probe_out   = (((CFW+1)'(tries) + (CFW+1)'(1)) >= (CFW+1)'(nf));
    stat.scan_empty  = (rd_mark == MK_EMPTY);
    stat.scan_last   = (CSW'(idx) == ns - CSW'(1));
    stat.pos_set     = pos_ok;
    stat.shift_last  = (idx_dn == pos_q);
    stat.range_empty = (lo >= hi_ex);
    stat.last_floor  = (CFW'(flr) == nf - CFW'(1));
    stat.srch_hit    = (rd_key == key_q);
    stat.srch_tomb   = (rd_mark == MK_TOMB);
    stat.q_remove    = (act_q == ACT_REMOVE);
  end

  // Slot memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    if (cmd.clr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else if (cmd.shift_wr) begin
      ram_we    = 1'b1;
      ram_waddr = {bkt, idx};
      ram_wdata = rd_entry;
    end else if (cmd.place) begin
      ram_we    = 1'b1;
      ram_waddr = {bkt, pos_q};
      ram_wdata = {key_q, MK_LIVE};
    end else if (cmd.srch_chk && stat.srch_hit && stat.q_remove) begin
      ram_we    = 1'b1;
      ram_waddr = {flr, mid_q};
      ram_wdata = {rd_key, MK_TOMB};
    end
    ram_raddr = '0;
    if (cmd.scan_rd) begin
      ram_raddr = {bkt, idx};
    end else if (cmd.shift_rd) begin
      ram_raddr = {bkt, idx_dn};
    end else if (cmd.srch_rd) begin
      ram_raddr = {flr, mid_w};
    end
  end

  // Fill count memory port selection
  assign fill_we    = cmd.clr || cmd.place;
  assign fill_waddr = cmd.clr ? clr_addr[FW-1:0] : bkt;
  assign fill_wdata = cmd.clr ? '0 : CSW'(fill_q + CSW'(1));

  bhts_ram #(.WIDTH(ENTRY_W), .DEPTH(1 << AW)) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  bhts_ram #(.WIDTH(CSW), .DEPTH(1 << FW)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (bkt),
    .rdata (fill_rd)
  );

  // Clearing sweep address and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      if (cmd.clr) clr_addr <= clr_addr + AW'(1);
      done <= cmd.fin;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q   <= key;
      act_q   <= action;
      rem_q   <= '0;
      bit_cnt <= BIT_CNT_W'(KEY_W - 1);
      flr     <= '0;
      lo      <= '0;
      hi_ex   <= ns;
    end
    if (cmd.mod_step) begin
      rem_q   <= rem_n;
      bit_cnt <= bit_cnt - BIT_CNT_W'(1);
      tries   <= '0;
      if (stat.mod_last) bkt <= FW'(rem_n);
    end
    // Linear probe to the next bucket, wrapping at the floor count
    if (cmd.probe_adv) begin
      tries <= tries + CFW'(1);
      if (CFW'(bkt) + CFW'(1) == nf) begin
        bkt <= '0;
      end else begin
        bkt <= bkt + FW'(1);
      end
    end
    if (cmd.scan_begin) begin
      fill_q <= fill_rd;
      idx    <= '0;
      pos_ok <= 1'b0;
    end
    // Find the first empty slot and the sorted insert position
    if (cmd.scan_chk) begin
      if (stat.scan_empty) begin
        if (!pos_ok) pos_q <= idx;
      end else begin
        if (!pos_ok && (key_q < rd_key)) begin
          pos_q  <= idx;
          pos_ok <= 1'b1;
        end
        idx <= idx + SW'(1);
      end
    end
    if (cmd.shift_wr) idx <= idx_dn;
    // Binary search: move to the next floor once the range is empty
    if (cmd.srch_rd) begin
      if (stat.range_empty) begin
        flr   <= flr + FW'(1);
        lo    <= '0;
        hi_ex <= ns;
      end else begin
        mid_q <= mid_w;
      end
    end
    if (cmd.srch_chk && !stat.srch_hit) begin
      if ((rd_key == '0) || (key_q < rd_key)) begin
        hi_ex <= CSW'(mid_q);
      end else begin
        lo <= CSW'(mid_q) + CSW'(1);
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      status <= cmd.fin_status;
      if (cmd.fin_status == ST_PLACED) begin
        floor <= bkt;
        slot  <= pos_q;
      end else if (cmd.fin_status == ST_FOUND) begin
        floor <= flr;
        slot  <= mid_q;
      end else begin
        floor <= '0;
        slot  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/bucketed_hash_table_sorted_buckets.sv =====
// Sorted-bucket hash table, top level. One item at a time; done pulses for one cycle.
// Add: key remainder by the floor count, a linear probe for a bucket with room, a scan
// of its slots, shifting entries, then place. Query/remove: binary search on each floor.
// Zero key or reserved action answers the cycle after start.
// Reset: config back to 16 floors, 8 slots; a clearing sweep over every slot address
// holds busy high. Results cannot be stalled.
`default_nettype none

module bucketed_hash_table_sorted_buckets #(
  parameter int FLOORS = 16,
  parameter int SLOTS  = 8
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       start,
  output logic                                            busy,
  input  wire logic [1:0]                                 action,
  input  wire logic [bhts_pkg::KEY_W-1:0]                 key,
  output logic                                            done,
  output logic [1:0]                                      status,
  output logic [((FLOORS > 1) ? $clog2(FLOORS) : 1)-1:0]  floor,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]    slot,
  input  wire logic                                       cfg_valid,
  output logic                                            cfg_ready,
  input  wire logic                                       cfg_index,
  input  wire logic [4:0]                                 cfg_data
);
  import bhts_pkg::*;

  logic [4:0] floors_cfg;
  logic [3:0] slots_cfg;
  dp_cmd_t    cmd;
  dp_stat_t   stat;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      floors_cfg <= FLOORS_RST;
      slots_cfg  <= SLOTS_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FLOORS) floors_cfg <= cfg_data;
      if (cfg_index == CFG_SLOTS)  slots_cfg  <= cfg_data[3:0];
    end
  end

  bhts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bhts_dpath #(.FLOORS(FLOORS), .SLOTS(SLOTS)) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .action     (action),
    .key        (key),
    .floors_cfg (floors_cfg),
    .slots_cfg  (slots_cfg),
    .done       (done),
    .status     (status),
    .floor      (floor),
    .slot       (slot)
  );

  // A result follows an accepted item or work in progress
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without an item in flight");

  // An accepted item either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item dropped");

  // Misses and full answers carry a zero location
  a_zero_loc: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_MISS || status == ST_FULL)) |-> (floor == '0 && slot == '0))
    else $error("nonzero location on miss or full");

endmodule

`default_nettype wire
